// ----- src/bpdt_pkg.sv -----
// Package for the battery idle power-down timer.
// Holds register indexes, field widths, limits and the configuration, tick and command structs.
// No dependencies.
package bpdt_pkg;

    localparam int unsigned IdleW   = 20;
    localparam int unsigned AlertW  = 16;
    localparam int unsigned HoursW  = 8;
    localparam int unsigned MinW    = 10;
    localparam int unsigned CfgW    = 10;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 8;

    localparam logic [IdleW-1:0]  IdleMax  = {IdleW{1'b1}};
    localparam logic [AlertW-1:0] AlertMax = {AlertW{1'b1}};
    localparam logic [11:0] SecPerHour = 12'd3600;
    localparam logic [5:0]  SecPerMin  = 6'd60;
    localparam logic [MinW-1:0] ShutMinReset = 10'd60;

    typedef enum logic [1:0] {
        REG_ENABLE     = 2'd0,
        REG_RADIO_HRS  = 2'd1,
        REG_MODEM_HRS  = 2'd2,
        REG_SHUT_MIN   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              enable;
        logic              radio_en;
        logic [IdleW-1:0]  radio_thr;
        logic              modem_en;
        logic [IdleW-1:0]  modem_thr;
        logic [AlertW-1:0] shut_thr;
    } t_cfg;

    typedef struct packed {
        logic charging_now;
        logic low_voltage_alert;
        logic radio_is_on;
        logic modem_is_on;
    } t_tick;

    typedef struct packed {
        logic radio_power_on;
        logic modem_power_on;
        logic radio_power_off;
        logic modem_power_off;
        logic full_shutdown;
    } t_cmd;

endpackage

// ----- src/bpdt_cfg.sv -----
// Configuration registers of the idle power-down timer.
// Converts hours and minutes to second thresholds on write. Uses bpdt_pkg.
module bpdt_cfg import bpdt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [CfgW-1:0] i_cfg_wdata,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_reg_idx w_idx;

    assign w_idx = t_reg_idx'(i_cfg_index);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (w_idx)
                REG_ENABLE: begin
                    n_cfg.enable = i_cfg_wdata[0];
                end
                REG_RADIO_HRS: begin
                    n_cfg.radio_en  = |i_cfg_wdata[HoursW-1:0];
                    n_cfg.radio_thr = IdleW'(i_cfg_wdata[HoursW-1:0]) * IdleW'(SecPerHour);
                end
                REG_MODEM_HRS: begin
                    n_cfg.modem_en  = |i_cfg_wdata[HoursW-1:0];
                    n_cfg.modem_thr = IdleW'(i_cfg_wdata[HoursW-1:0]) * IdleW'(SecPerHour);
                end
                REG_SHUT_MIN: begin
                    n_cfg.shut_thr = AlertW'(i_cfg_wdata[MinW-1:0]) * AlertW'(SecPerMin);
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.radio_en  <= 1'b0;
            r_cfg.radio_thr <= '0;
            r_cfg.modem_en  <= 1'b0;
            r_cfg.modem_thr <= '0;
            r_cfg.shut_thr  <= AlertW'(ShutMinReset) * AlertW'(SecPerMin);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/bpdt_in_stage.sv -----
// Input register of the idle power-down timer.
// Holds one tick request until the core takes it. Uses bpdt_pkg.
module bpdt_in_stage import bpdt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_tick  i_tick,
    output logic   o_valid,
    input  logic   i_take,
    output t_tick  o_tick
);

    logic  r_valid;
    t_tick r_tick;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tick <= i_tick;
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

// ----- src/bpdt_core.sv -----
// Timer state and power rules of the idle power-down timer.
// Updates counters per tick and registers the command result. Uses bpdt_pkg.
module bpdt_core import bpdt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_tick i_tick,
    output logic  o_take,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cmd  o_cmd
);

    logic [IdleW-1:0]  r_idle,  n_idle;
    logic [AlertW-1:0] r_alert, n_alert;
    logic r_was_chg,   n_was_chg;
    logic r_radio_off, n_radio_off;
    logic r_modem_off, n_modem_off;
    logic r_valid;
    t_cmd r_cmd, n_cmd;
    logic w_radio_on, w_modem_on;
    logic [AlertW-1:0] w_alert_inc;

    assign o_take = i_valid && (!r_valid || i_ready);

    always_comb begin
        n_idle      = r_idle;
        n_alert     = r_alert;
        n_was_chg   = r_was_chg;
        n_radio_off = r_radio_off;
        n_modem_off = r_modem_off;
        n_cmd       = '0;
        w_radio_on  = i_tick.radio_is_on;
        w_modem_on  = i_tick.modem_is_on;
        w_alert_inc = (r_alert != AlertMax) ? r_alert + AlertW'(1) : r_alert;

        if (!r_was_chg && r_idle != IdleMax) begin
            n_idle = r_idle + IdleW'(1);
        end

        if (i_tick.charging_now) begin
            if (!r_was_chg) begin
                n_was_chg = 1'b1;
                if (r_radio_off) begin
                    n_cmd.radio_power_on = 1'b1;
                    w_radio_on  = 1'b1;
                    n_radio_off = 1'b0;
                end
                if (r_modem_off) begin
                    n_cmd.modem_power_on = 1'b1;
                    w_modem_on  = 1'b1;
                    n_modem_off = 1'b0;
                end
            end
        end else if (r_was_chg) begin
            n_was_chg = 1'b0;
            n_idle    = '0;
        end

        if (i_cfg.enable) begin
            if (i_cfg.radio_en && n_idle > i_cfg.radio_thr && w_radio_on) begin
                n_cmd.radio_power_off = 1'b1;
                w_radio_on  = 1'b0;
                n_radio_off = 1'b1;
            end
            if (i_cfg.modem_en && n_idle > i_cfg.modem_thr && w_modem_on) begin
                n_cmd.modem_power_off = 1'b1;
                w_modem_on  = 1'b0;
                n_modem_off = 1'b1;
            end
            if (i_tick.low_voltage_alert) begin
                n_alert = w_alert_inc;
                if (w_alert_inc > i_cfg.shut_thr) begin
                    n_cmd.full_shutdown = 1'b1;
                    if (w_modem_on) begin
                        n_cmd.modem_power_off = 1'b1;
                        n_modem_off = 1'b1;
                    end
                    if (w_radio_on) begin
                        n_cmd.radio_power_off = 1'b1;
                        n_radio_off = 1'b1;
                    end
                end
            end else begin
                n_alert = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle      <= '0;
            r_alert     <= '0;
            r_was_chg   <= 1'b0;
            r_radio_off <= 1'b0;
            r_modem_off <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (o_take) begin
                r_idle      <= n_idle;
                r_alert     <= n_alert;
                r_was_chg   <= n_was_chg;
                r_radio_off <= n_radio_off;
                r_modem_off <= n_modem_off;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ----- src/battery_idle_power_down_timer.sv -----
// Top level of the battery idle power-down timer.
// Joins configuration, input register and timer core. Uses bpdt_pkg.
//
// Each request on the slave stream is one one-second tick carrying the
// charging flag, the low-voltage alert flag and the radio and modem power
// states. Each tick produces exactly one request on the master stream with
// the power-on, power-off and full-shutdown commands for that tick.
// Configuration is a write-only port: enable, radio and modem idle hours
// and shutdown minutes, indexed 0 to 3; write only while no tick is pending.
// A tick accepted on the slave side sits in the input register and passes the
// rule logic into the result register, which drives master valid.
// Throughput is one tick per cycle while the master side takes each request.
// When the master side stalls, the result register holds its request and one
// more tick waits in the input register; the slave side then drops tready.
// Reset clears the counters, the charging and turned-off flags and both
// valid bits, and loads the register defaults (disabled, no idle delays,
// 60 shutdown minutes).
module battery_idle_power_down_timer import bpdt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [0] charging_now, [1] low_voltage_alert, [2] radio_is_on, [3] modem_is_on
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [0] radio_power_on, [1] modem_power_on, [2] radio_power_off,
    // [3] modem_power_off, [4] full_shutdown
    output logic [OutDataW-1:0] o_m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CfgW-1:0]     i_cfg_wdata
);

    t_cfg  w_cfg;
    t_tick w_in_tick, w_core_tick;
    t_cmd  w_cmd;
    logic  w_in_valid;
    logic  w_take;

    assign w_in_tick.charging_now      = i_s_axis_tdata[0];
    assign w_in_tick.low_voltage_alert = i_s_axis_tdata[1];
    assign w_in_tick.radio_is_on       = i_s_axis_tdata[2];
    assign w_in_tick.modem_is_on       = i_s_axis_tdata[3];

    bpdt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    bpdt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_tick  (w_in_tick),
        .o_valid (w_in_valid),
        .i_take  (w_take),
        .o_tick  (w_core_tick)
    );

    bpdt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_in_valid),
        .i_tick  (w_core_tick),
        .o_take  (w_take),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_cmd   (w_cmd)
    );

    assign o_m_axis_tdata = {3'b000, w_cmd.full_shutdown, w_cmd.modem_power_off,
                             w_cmd.radio_power_off, w_cmd.modem_power_on,
                             w_cmd.radio_power_on};

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_valid |-> o_s_axis_tready)
        else $error("input stage empty but tready low");

    a_advance_to_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_valid && !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("pending tick did not reach result register");

    a_take_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (w_in_valid && (!o_m_axis_tvalid || i_m_axis_tready)))
        else $error("core took a tick without room in result register");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for battery_idle_power_down_timer: directed ticks, then random
// charge/idle sessions, checked against fixed commands or an in-bench model of the timer rules.
// Depends on bpdt_pkg and the timer RTL; needs no other files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpdt_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // [0] charging_now, [1] low_voltage_alert, [2] radio_is_on, [3] modem_is_on
    logic [InDataW-1:0]  i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b1;
    // [0] radio_power_on, [1] modem_power_on, [2] radio_power_off,
    // [3] modem_power_off, [4] full_shutdown
    logic [OutDataW-1:0] o_m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = REG_ENABLE;
    logic [CfgW-1:0]     i_cfg_wdata = '0;

    battery_idle_power_down_timer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("tb: errors");
        $finish;
    end

    // timer model state and register shadow
    logic [IdleW-1:0]  idle_secs = '0;
    logic [AlertW-1:0] alert_secs = '0;
    logic              was_chg = 1'b0;
    logic              radio_cut = 1'b0;
    logic              modem_cut = 1'b0;
    logic              cfg_en = 1'b0;
    logic [HoursW-1:0] radio_hrs = '0;
    logic [HoursW-1:0] modem_hrs = '0;
    logic [MinW-1:0]   shut_min = ShutMinReset;

    t_cmd pending_cmds[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   gap_mode = 1;
    int   stall_mode = 1;
    int   burst_left = 0;
    int   ready_left = 0;

    typedef struct {
        bit          is_cfg;
        t_reg_idx    reg_sel;
        int unsigned value;
        t_tick       tk;
        int unsigned reps;
        bit          known;
        t_cmd        cmd;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic t_cmd tick_commands(t_tick tk);
        t_cmd        c;
        logic        r_on;
        logic        m_on;
        logic [31:0] idle_w;
        logic [31:0] thr;
        c = '0;
        r_on = tk.radio_is_on;
        m_on = tk.modem_is_on;
        if (!was_chg && idle_secs != IdleMax) idle_secs++;
        if (tk.charging_now) begin
            if (!was_chg) begin
                was_chg = 1'b1;
                if (radio_cut) begin
                    c.radio_power_on = 1'b1;
                    r_on = 1'b1;
                    radio_cut = 1'b0;
                end
                if (modem_cut) begin
                    c.modem_power_on = 1'b1;
                    m_on = 1'b1;
                    modem_cut = 1'b0;
                end
            end
        end else if (was_chg) begin
            was_chg = 1'b0;
            idle_secs = '0;
        end
        if (cfg_en) begin
            idle_w = 32'(idle_secs);
            thr = 32'(radio_hrs) * 32'(SecPerHour);
            if (radio_hrs != 0 && idle_w > thr && r_on) begin
                c.radio_power_off = 1'b1;
                r_on = 1'b0;
                radio_cut = 1'b1;
            end
            thr = 32'(modem_hrs) * 32'(SecPerHour);
            if (modem_hrs != 0 && idle_w > thr && m_on) begin
                c.modem_power_off = 1'b1;
                m_on = 1'b0;
                modem_cut = 1'b1;
            end
            if (tk.low_voltage_alert) begin
                if (alert_secs != AlertMax) alert_secs++;
                thr = 32'(shut_min) * 32'(SecPerMin);
                if ({16'd0, alert_secs} > thr) begin
                    c.full_shutdown = 1'b1;
                    if (m_on) begin
                        c.modem_power_off = 1'b1;
                        modem_cut = 1'b1;
                    end
                    if (r_on) begin
                        c.radio_power_off = 1'b1;
                        radio_cut = 1'b1;
                    end
                end
            end else begin
                alert_secs = '0;
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 50) $display("%0t: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %b want %b",
                                      results_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_cmd want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                want = pending_cmds.pop_front();
                check_field("radio_power_on", 3'(o_m_axis_tdata[0]),
                            3'(want.radio_power_on));
                check_field("modem_power_on", 3'(o_m_axis_tdata[1]),
                            3'(want.modem_power_on));
                check_field("radio_power_off", 3'(o_m_axis_tdata[2]),
                            3'(want.radio_power_off));
                check_field("modem_power_off", 3'(o_m_axis_tdata[3]),
                            3'(want.modem_power_off));
                check_field("full_shutdown", 3'(o_m_axis_tdata[4]),
                            3'(want.full_shutdown));
                check_field("pad", o_m_axis_tdata[7:5], 3'b000);
            end
            results_seen++;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            case (stall_mode)
                0: begin
                    i_m_axis_tready = 1'b1;
                    ready_left = 16;
                end
                1: begin
                    i_m_axis_tready = ($urandom_range(0, 2) != 0);
                    ready_left = $urandom_range(1, 12);
                end
                default: begin
                    i_m_axis_tready = 1'($urandom_range(0, 1));
                    ready_left = 1;
                end
            endcase
        end else begin
            ready_left--;
        end
    end

    task automatic send_tick(input t_tick tk, input bit known, input t_cmd typed);
        t_cmd pred;
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = InDataW'({tk.modem_is_on, tk.radio_is_on,
                                   tk.low_voltage_alert, tk.charging_now});
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = tick_commands(tk);
        pending_cmds.push_back(known ? typed : pred);
        @(negedge i_clk);
        if (gap_mode != 0) begin
            if (burst_left == 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CfgW-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        case (idx)
            REG_ENABLE:    cfg_en = val[0];
            REG_RADIO_HRS: radio_hrs = val[HoursW-1:0];
            REG_MODEM_HRS: modem_hrs = val[HoursW-1:0];
            REG_SHUT_MIN:  shut_min = val[MinW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic void add_tick(bit chg, bit alert, bit radio, bit modem,
                                     int unsigned reps, bit known, t_cmd cmd);
        t_plan_row r;
        r.is_cfg = 1'b0;
        r.reg_sel = REG_ENABLE;
        r.value = 0;
        r.tk = {chg, alert, radio, modem};
        r.reps = reps;
        r.known = known;
        r.cmd = cmd;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(t_reg_idx idx, int unsigned val);
        t_plan_row r;
        r.is_cfg = 1'b1;
        r.reg_sel = idx;
        r.value = val;
        r.tk = '0;
        r.reps = 0;
        r.known = 1'b0;
        r.cmd = '0;
        plan.push_back(r);
    endfunction

    function automatic int unsigned pick_hours();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned pick_minutes();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // charge bursts followed by idle stretches, alert in runs, power states mostly
    // following the commands; the rest is noise
    task automatic run_phase(input int unsigned n_items, input bit with_long);
        int unsigned made;
        int unsigned chg_len;
        int unsigned idle_len;
        int unsigned flip_div;
        bit          long_run;
        logic        alert_lvl;
        t_tick       tk;
        made = 0;
        alert_lvl = 1'b0;
        while (made < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                chg_len = $urandom_range(0, 4);
                idle_len = $urandom_range(1, 40);
                long_run = with_long;
                if (long_run) begin
                    idle_len = $urandom_range(3550, 7400);
                    with_long = 1'b0;
                end
                flip_div = $urandom_range(2, 150);
                for (int i = 0; i < chg_len + idle_len; i++) begin
                    if ($urandom_range(1, flip_div) == 1) alert_lvl = ~alert_lvl;
                    tk.charging_now = (i < chg_len);
                    tk.low_voltage_alert = alert_lvl;
                    tk.radio_is_on = ($urandom_range(0, 9) != 0) ? ~radio_cut
                                                                 : 1'($urandom_range(0, 1));
                    tk.modem_is_on = ($urandom_range(0, 9) != 0) ? ~modem_cut
                                                                 : 1'($urandom_range(0, 1));
                    send_tick(tk, 1'b0, '0);
                end
                if (!long_run) made += chg_len + idle_len;
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    tk = t_tick'(4'($urandom_range(0, 15)));
                    send_tick(tk, 1'b0, '0);
                    made++;
                end
            end
        end
    endtask

    initial begin
        bit long_phase;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // tick bits: charging, alert, radio, modem
        // command bits: radio on, modem on, radio off, modem off, shutdown
        add_tick(0, 0, 0, 0, 1, 1, 5'b00000);
        add_tick(1, 1, 1, 1, 1, 1, 5'b00000);
        add_tick(0, 1, 1, 1, 1, 1, 5'b00000);
        add_cfg(REG_ENABLE, 1);
        add_cfg(REG_SHUT_MIN, 0);
        add_tick(0, 1, 1, 1, 1, 1, 5'b00111);
        add_tick(0, 1, 0, 0, 1, 1, 5'b00001);
        add_tick(1, 0, 0, 0, 1, 1, 5'b11000);
        add_tick(1, 1, 1, 0, 1, 1, 5'b00101);
        add_tick(0, 0, 0, 0, 1, 1, 5'b00000);
        add_cfg(REG_SHUT_MIN, 1);
        add_tick(0, 1, 1, 1, 61, 0, '0);
        add_tick(1, 1, 0, 0, 1, 0, '0);
        add_cfg(REG_RADIO_HRS, 1);
        add_cfg(REG_MODEM_HRS, 2);
        add_cfg(REG_SHUT_MIN, 1023);
        add_tick(0, 0, 1, 1, 3603, 0, '0);
        add_tick(0, 0, 0, 1, 3600, 0, '0);
        add_tick(1, 0, 0, 0, 1, 0, '0);
        add_tick(0, 1, 1, 1, 3, 0, '0);
        add_cfg(REG_ENABLE, 0);
        add_tick(0, 1, 1, 1, 5, 0, '0);
        add_tick(1, 0, 1, 1, 1, 0, '0);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain();
                write_reg(plan[k].reg_sel, CfgW'(plan[k].value));
            end else begin
                repeat (plan[k].reps) send_tick(plan[k].tk, plan[k].known, plan[k].cmd);
            end
        end

        for (int p = 0; p < 8; p++) begin
            long_phase = (p % 2 == 0);
            drain();
            write_reg(REG_ENABLE, (p == 3) ? CfgW'(0) : CfgW'(1));
            write_reg(REG_RADIO_HRS, long_phase ? CfgW'($urandom_range(1, 2))
                                                : CfgW'(pick_hours()));
            write_reg(REG_MODEM_HRS, CfgW'(pick_hours()));
            write_reg(REG_SHUT_MIN, CfgW'(pick_minutes()));
            gap_mode = (p % 3 != 0);
            stall_mode = p % 3;
            run_phase(125, long_phase);
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
